>>> src/plcl_pkg.sv
// Shared types and constants for the piecewise-linear curve lookup block.
package plcl_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_END   = 3'd2;
  localparam logic [2:0] ST_DISCONT   = 3'd3;
  localparam logic [2:0] ST_LOOPS     = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_NO_TABLE  = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int ONE_Q16 = 65536;
  localparam int DIV_STEPS = 38;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_QCHK, S_SRCH, S_SWAIT, S_FETCH, S_FWAIT,
    S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;     // register the accepted item
    logic do_load;     // run load checks and write the table
    logic srch_init;   // set up search bounds
    logic srch_rd;     // read x at mid
    logic srch_upd;    // update bounds from read data
    logic rd_lo;       // read entry at lo
    logic rd_hi;       // read entry at hi
    logic lat_lo;      // latch entry at lo
    logic lat_hi;      // latch entry at hi
    logic mul;         // form product
    logic div_step;    // one quotient bit
    logic fin;         // form final value
    logic set_q;       // query result without interpolation
    logic out_load;    // result register of load
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic opcode;
    logic table_ok;
    logic clamp;       // query answered without search
    logic srch_done;
    logic div_done;
  } sts_t;

endpackage

>>> src/piecewise_linear_curve_lookup_top.sv
// Piecewise-linear timing curve lookup: top level.
//
// One input channel (in_valid/in_stall) carries either a load of one
// curve point (opcode 0) or a query at time query_t (opcode 1). Each
// input transfer gives exactly one output transfer (out_valid/out_stall)
// with status and value. One item is in flight at a time; in_stall is
// high from the cycle after a transfer until its result is taken, and
// the next input transfer can follow in the cycle after the result transfer.
// A load runs its checks and table write; a query that needs no search
// is answered without interpolation; an interpolating query runs the
// binary search (up to 10 steps at 1024 points), the final read, segment
// fetch and multiply, the bit-serial divider and the final value step.
// The result holds while out_stall is high.
// Reset (rst, synchronous) clears the point count, load error and table
// valid flag; table RAM contents are left as they were and are only read
// below the point count.
module piecewise_linear_curve_lookup_top #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic               first_point,
  input  logic               last_point,
  input  logic [16:0]        point_fraction,
  input  logic [16:0]        point_x,
  input  logic signed [19:0] point_y,
  input  logic signed [17:0] query_t,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [19:0] value
);
  import plcl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  plcl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  plcl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .opcode(opcode), .first_point(first_point),
    .last_point(last_point), .point_fraction(point_fraction),
    .point_x(point_x), .point_y(point_y), .query_t(query_t),
    .status(status), .value(value), .cmd(cmd), .sts(sts));
endmodule

>>> src/plcl_ram.sv
// Generic single-port RAM with registered read.
module plcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/plcl_ctrl.sv
// Controller state machine sequencing loads and queries.
module plcl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  plcl_pkg::sts_t  sts,
  output plcl_pkg::cmd_t  cmd
);
  import plcl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_QCHK;
      S_QCHK: begin
        if (sts.opcode == OP_LOAD) state_next = S_LOAD;
        else if (!sts.table_ok || sts.clamp) state_next = S_OUT;
        else state_next = S_SRCH;
      end
      S_LOAD:   state_next = S_OUT;
      S_SRCH:   state_next = sts.srch_done ? S_FETCH : S_SWAIT;
      S_SWAIT:  state_next = S_SRCH;
      S_FETCH:  state_next = S_FWAIT;
      S_FWAIT:  state_next = S_MUL;
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (sts.div_done) state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE:   cmd.capture = in_valid;
      S_QCHK: begin
        cmd.set_q = (sts.opcode == OP_QUERY);
        cmd.srch_init = (sts.opcode == OP_QUERY);
      end
      S_LOAD:   begin cmd.do_load = 1'b1; cmd.out_load = 1'b1; end
      S_SRCH:   begin cmd.srch_rd = !sts.srch_done; cmd.rd_lo = sts.srch_done; end
      S_SWAIT:  cmd.srch_upd = 1'b1;
      // RAM data for lo arrives while hi is being addressed
      S_FETCH:  begin cmd.rd_hi = 1'b1; cmd.lat_lo = 1'b1; end
      S_FWAIT:  cmd.lat_hi = 1'b1;
      S_MUL:    cmd.mul = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_FIN:    cmd.fin = 1'b1;
      default:  ;
    endcase
  end
endmodule

>>> src/plcl_dp.sv
// Datapath: load checks, point tables, search bounds and interpolation.
module plcl_dp #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                opcode,
  input  logic                first_point,
  input  logic                last_point,
  input  logic [16:0]         point_fraction,
  input  logic [16:0]         point_x,
  input  logic signed [19:0]  point_y,
  input  logic signed [17:0]  query_t,
  output logic [2:0]          status,
  output logic signed [19:0]  value,
  input  plcl_pkg::cmd_t      cmd,
  output plcl_pkg::sts_t      sts
);
  import plcl_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Captured item
  logic        op_r, first_r, last_r;
  logic [16:0] frac_r, x_r;
  logic signed [19:0] y_r;
  logic signed [17:0] t_r;

  // Load state
  logic [CW-1:0] point_count;
  logic [16:0]   previous_x, previous_fraction;
  logic [2:0]    load_error;
  logic          table_valid;

  // Search and arithmetic
  logic [CW-1:0] lo, hi;
  logic [AW-1:0] raddr;
  logic [16:0]   x_rd;
  logic signed [19:0] y_rd;
  logic [16:0]   xs, xe;
  logic signed [19:0] ys, ye;
  logic [37:0]   num_mag;   // |(t-xs)*(ye-ys)|
  logic          neg;
  logic [37:0]   quo;
  logic [17:0]   rem;
  logic [16:0]   den;
  logic [5:0]    div_cnt;
  logic          zero_w;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= opcode; first_r <= first_point; last_r <= last_point;
      frac_r <= point_fraction; x_r <= point_x; y_r <= point_y; t_r <= query_t;
    end
  end

  // Load checks on the captured point
  logic [CW-1:0] cnt_b;
  logic [16:0]   px_b, pf_b;
  logic [2:0]    err_b, err_new;
  logic          store;
  always_comb begin
    cnt_b = first_r ? '0 : point_count;
    px_b  = first_r ? '0 : previous_x;
    pf_b  = first_r ? '0 : previous_fraction;
    err_b = first_r ? ST_OK : load_error;
    err_new = err_b;
    if (err_b == ST_OK) begin
      if (first_r && (x_r != 17'd0 || y_r != 20'sd0)) err_new = ST_BAD_START;
      else if (last_r && (x_r != 17'(ONE_Q16) || y_r != 20'sd65536)) err_new = ST_BAD_END;
      else if (frac_r == pf_b && x_r != px_b) err_new = ST_DISCONT;
      else if (x_r < px_b) err_new = ST_LOOPS;
      else if (cnt_b == CW'(MAX_POINTS)) err_new = ST_FULL;
    end
    store = cmd.do_load && (err_new == ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0; previous_x <= '0; previous_fraction <= '0;
      load_error <= ST_OK; table_valid <= 1'b0;
    end else if (cmd.do_load) begin
      load_error <= err_new;
      table_valid <= store && last_r;
      point_count <= store ? cnt_b + CW'(1) : cnt_b;
      previous_x <= store ? x_r : px_b;
      previous_fraction <= store ? frac_r : pf_b;
    end
  end

  // Table address select
  logic [CW-1:0] mid;
  assign mid = CW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  always_comb begin
    if (store)           raddr = cnt_b[AW-1:0];
    else if (cmd.rd_lo)  raddr = lo[AW-1:0];
    else if (cmd.rd_hi)  raddr = hi[AW-1:0];
    else                 raddr = mid[AW-1:0];
  end

  plcl_ram #(.WIDTH(17), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(store), .addr(raddr), .wdata(x_r), .rdata(x_rd));
  plcl_ram #(.WIDTH(20), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(store), .addr(raddr), .wdata(y_r), .rdata(y_rd));

  // Search bounds
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo <= '0; hi <= point_count - CW'(1);
    end else if (cmd.srch_upd) begin
      if ($signed({1'b0, t_r}) < $signed({2'b00, x_rd})) hi <= mid;
      else lo <= mid;
    end
  end

  // Segment fetch, multiply, divide
  logic signed [18:0] dt;
  logic signed [20:0] dy;
  logic signed [39:0] prod;
  assign dt = 19'(t_r) - $signed({2'b00, xs});
  assign dy = 21'(ye) - 21'(ys);
  assign prod = dt * dy;
  logic [18:0] trial;
  assign trial = {rem, quo[37]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (cmd.lat_lo) begin xs <= x_rd; ys <= y_rd; end
    if (cmd.lat_hi) begin xe <= x_rd; ye <= y_rd; end
    if (cmd.mul) begin
      neg <= prod[39];
      quo <= 38'(prod[39] ? -prod : prod);
      rem <= '0;
      den <= xe - xs;
      zero_w <= (xe == xs);
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
      if (!trial[18]) begin
        rem <= trial[17:0]; quo <= {quo[36:0], 1'b1};
      end else begin
        rem <= {rem[16:0], quo[37]}; quo <= {quo[36:0], 1'b0};
      end
    end
  end

  // Result register
  logic signed [40:0] sq, r;
  assign sq = neg ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
  assign r = 41'(ys) + sq;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= err_new; value <= '0;
    end else if (cmd.set_q) begin
      if (!sts.table_ok) begin status <= ST_NO_TABLE; value <= '0; end
      else begin
        status <= ST_OK;
        value <= (t_r >= 18'sd65536) ? 20'sd65536 : 20'sd0;
      end
    end else if (cmd.fin) begin
      if (zero_w) value <= ys;
      else if (r > 41'sd524287) value <= 20'sd524287;
      else if (r < -41'sd524288) value <= -20'sd524288;
      else value <= r[19:0];
    end
  end

  assign sts.opcode = op_r;
  assign sts.table_ok = table_valid && (point_count != '0);
  assign sts.clamp = (t_r <= 18'sd0) || (t_r >= 18'sd65536);
  assign sts.srch_done = (hi - lo) <= CW'(1);
  assign sts.div_done = (div_cnt == 6'(DIV_STEPS - 1));
endmodule

>>> sim/tb_top.sv
// Testbench for the piecewise-linear curve lookup block: directed and random loads and queries.
`timescale 1ns / 100ps

module tb_top;
  import plcl_pkg::*;

  localparam int N_PTS = 1024;
  localparam int PW = $clog2(N_PTS);
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = OP_LOAD;
  logic               first_point = 1'b0;
  logic               last_point = 1'b0;
  logic [16:0]        point_fraction = '0;
  logic [16:0]        point_x = '0;
  logic signed [19:0] point_y = '0;
  logic signed [17:0] query_t = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic signed [19:0] value;

  piecewise_linear_curve_lookup_top #(.MAX_POINTS(N_PTS)) i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .first_point(first_point), .last_point(last_point),
    .point_fraction(point_fraction), .point_x(point_x), .point_y(point_y),
    .query_t(query_t), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .value(value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted curve table and load tracking
  logic [16:0]        curve_x[N_PTS];
  logic signed [19:0] curve_y[N_PTS];
  int unsigned        pts_stored;
  logic [16:0]        last_x;
  logic [16:0]        last_frac;
  logic [2:0]         load_err;
  logic               curve_ok;

  typedef struct {
    logic [2:0]         status;
    logic signed [19:0] value;
  } curve_result_t;

  curve_result_t expected_q[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            hold_off = 1'b0;
  bit            drain_wait = 1'b0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic signed [19:0] interpolate(input int t);
    int unsigned lo, hi, mid;
    longint xs, xe, ys, ye, r;
    lo = 0;
    if (t <= 0) return '0;
    if (t >= ONE_Q16) return 20'sd65536;
    hi = pts_stored - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (t < int'(curve_x[mid[PW-1:0]])) hi = mid;
      else lo = mid;
    end
    xs = curve_x[lo[PW-1:0]];
    xe = curve_x[hi[PW-1:0]];
    ys = curve_y[lo[PW-1:0]];
    ye = curve_y[hi[PW-1:0]];
    if (xe == xs) return ys[19:0];
    // SV division truncates toward zero
    r = ys + ((longint'(t) - xs) * (ye - ys)) / (xe - xs);
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[19:0];
  endfunction

  // Predict the result of one accepted item
  function automatic curve_result_t predict_curve(input logic op, input logic fp,
      input logic lp, input logic [16:0] fr, input logic [16:0] x,
      input logic signed [19:0] y, input logic signed [17:0] t);
    curve_result_t res;
    res.value = '0;
    if (op == OP_LOAD) begin
      if (fp) begin
        pts_stored = 0;
        last_x = '0;
        last_frac = '0;
        load_err = ST_OK;
      end
      curve_ok = 1'b0;
      if (load_err == ST_OK) begin
        if (fp && (x != 17'd0 || y != 20'sd0)) load_err = ST_BAD_START;
        else if (lp && (x != 17'(ONE_Q16) || y != 20'(ONE_Q16))) load_err = ST_BAD_END;
        else if (fr == last_frac && x != last_x) load_err = ST_DISCONT;
        else if (x < last_x) load_err = ST_LOOPS;
        else if (pts_stored >= N_PTS) load_err = ST_FULL;
        if (load_err == ST_OK) begin
          curve_x[pts_stored[PW-1:0]] = x;
          curve_y[pts_stored[PW-1:0]] = y;
          pts_stored++;
          last_x = x;
          last_frac = fr;
          if (lp) curve_ok = 1'b1;
        end
      end
      res.status = load_err;
    end else if (!curve_ok || pts_stored == 0) begin
      res.status = ST_NO_TABLE;
    end else begin
      res.status = ST_OK;
      res.value = interpolate(int'(t));
    end
    return res;
  endfunction

  // Send one item after a random gap and record its expected result
  task automatic send_item(input logic op, input logic fp, input logic lp,
      input logic [16:0] fr, input logic [16:0] x, input logic signed [19:0] y,
      input logic signed [17:0] t);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (drain_wait) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    first_point <= fp;
    last_point <= lp;
    point_fraction <= fr;
    point_x <= x;
    point_y <= y;
    query_t <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_curve(op, fp, lp, fr, x, y, t));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_load(input logic fp, input logic lp, input logic [16:0] fr,
      input logic [16:0] x, input logic signed [19:0] y);
    send_item(OP_LOAD, fp, lp, fr, x, y, 18'($urandom));
  endtask

  task automatic send_query(input logic signed [17:0] t);
    send_item(OP_QUERY, 1'($urandom), 1'($urandom), 17'($urandom), 17'($urandom),
              20'($urandom), t);
  endtask

  // Well-formed curve of n points with random interior content
  task automatic load_curve(input int n, input bit wild_y);
    int unsigned x, fr;
    x = 0;
    fr = 0;
    send_load(1'b1, n == 1, '0, '0, '0);
    for (int i = 1; i < n; i++) begin
      if (i == n - 1) begin
        send_load(1'b0, 1'b1, 17'(ONE_Q16), 17'(ONE_Q16), 20'sd65536);
      end else begin
        if ($urandom_range(0, 4) != 0)
          x = x + $urandom_range(0, (ONE_Q16 - x) / (n - i));
        fr = fr + 1 + $urandom_range(0, 40);
        send_load(1'b0, 1'b0, fr[16:0], x[16:0],
                  wild_y ? 20'($urandom) : 20'($urandom_range(0, 131072)));
      end
    end
  endtask

  function automatic logic signed [17:0] rand_t();
    case ($urandom_range(0, 7))
      0: return 18'($urandom);
      1: return 18'sd0;
      2: return 18'sd65536;
      3: return 18'($urandom_range(65537, 131071));
      default: return 18'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic test_no_table();
    send_query(18'sd100);
    send_query(18'sh1FFFF);
    send_query(18'sh20000);
  endtask

  task automatic test_load_errors();
    send_load(1'b1, 1'b0, 17'h1FFFF, 17'd5, 20'sd0);        // bad start
    send_load(1'b0, 1'b1, '0, 17'(ONE_Q16), 20'sd65536);    // ignored after error
    send_load(1'b1, 1'b0, '0, '0, 20'sh80000);
    send_load(1'b1, 1'b0, '0, '0, '0);
    send_load(1'b0, 1'b1, 17'd9, 17'd100, 20'sd65536);      // bad end
    send_load(1'b1, 1'b0, '0, '0, '0);
    send_load(1'b0, 1'b0, '0, 17'd50, 20'sd3);              // discontinuity
    send_load(1'b1, 1'b0, '0, '0, '0);
    send_load(1'b0, 1'b0, 17'd4, 17'd900, 20'sh7FFFF);
    send_load(1'b0, 1'b0, 17'd8, 17'd800, 20'sd3);          // loops back
    send_query(18'sd300);
  endtask

  task automatic test_short_tables();
    // continuation from reset state, one point table
    send_load(1'b0, 1'b1, 17'd1, 17'(ONE_Q16), 20'sd65536);
    send_query(18'sd7);
    send_load(1'b1, 1'b1, '0, '0, '0);                      // first and last
    send_query(18'sd7);
    // steep first segment
    send_load(1'b1, 1'b0, '0, '0, '0);
    send_load(1'b0, 1'b0, 17'd3, 17'd40000, 20'sh80000);
    send_load(1'b0, 1'b1, 17'd5, 17'(ONE_Q16), 20'sd65536);
    send_query(18'sd1);
    send_load(1'b0, 1'b0, 17'd6, 17'd60000, 20'sh7FFFF);
    send_load(1'b0, 1'b0, 17'd7, 17'd60000, 20'sh80000);    // ignored after error
    send_load(1'b0, 1'b1, 17'd8, 17'(ONE_Q16), 20'sd65536);
    send_query(18'sd60000);
    send_query(18'sd50000);
    send_query(18'sd65535);
  endtask

  // Fill the table exactly, query it, then overflow it by one point
  task automatic test_full_table();
    send_load(1'b1, 1'b0, '0, '0, '0);
    for (int i = 1; i < N_PTS - 1; i++)
      send_load(1'b0, 1'b0, 17'(i), 17'(i * 64), 20'($urandom));
    send_load(1'b0, 1'b1, 17'(N_PTS - 1), 17'(ONE_Q16), 20'sd65536);
    for (int i = 0; i < 20; i++) send_query(rand_t());
    send_load(1'b0, 1'b0, 17'h1FFFF, 17'(ONE_Q16), 20'sd65536);  // table full
    send_query(rand_t());
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_query(rand_t());
    wait (!hold_off);
  endtask

  task automatic test_random(input int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
        load_curve(n, 1'($urandom_range(0, 1)));
        sent += n;
        for (int i = $urandom_range(3, 20); i > 0; i--) begin
          send_query(rand_t());
          sent++;
        end
      end else begin
        // noise: arbitrary loads and queries
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          if ($urandom_range(0, 1) != 0)
            send_load($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      17'($urandom), 17'($urandom), 20'($urandom));
          else
            send_query(rand_t());
          sent++;
        end
      end
    end
  endtask

  // Receiver stall: random per item, and a long hold-off on request
  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        while (!(out_valid && !out_stall)) @(posedge clk);
        continue;
      end
      @(posedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        curve_result_t want;
        want = expected_q.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (value !== want.value)
          report($sformatf("value %0d, expected %0d", value, want.value));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    pts_stored = 0;
    last_x = '0;
    last_frac = '0;
    load_err = ST_OK;
    curve_ok = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_table();
    test_short_tables();
    test_load_errors();
    test_backpressure();
    test_full_table();
    test_random(700);
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
src/plcl_pkg.sv
src/plcl_ram.sv
src/plcl_ctrl.sv
src/plcl_dp.sv
src/piecewise_linear_curve_lookup_top.sv
sim/tb_top.sv
